[rtl/caldc_pkg.sv]
`timescale 1ns / 1ps
// caldc_pkg: item types, command/status structs and calendar helper functions
// shared by the controller, the datapath and the top level of the date counter
// no dependencies
package caldc_pkg;

    localparam int unsigned YEAR_MAX = 9999;

    // function codes of an input item
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_NEXT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // last julian year, also the year of the april gap
    localparam logic [13:0] GAP_YEAR    = 14'd1916;
    localparam logic [4:0]  GAP_DAYS    = 5'd13;
    localparam logic [4:0]  GAP_END_DAY = 5'd14;

    // divisibility by 25: y * inverse(25) mod 2^14 lands in 0..655 only for multiples
    localparam logic [13:0] INV25     = 14'd7209;
    localparam logic [13:0] DIV25_MAX = 14'd655;

    // floor(x / 100) for x < 2^14 as (x * 5243) >> 19
    localparam logic [26:0] RECIP100       = 27'd5243;
    localparam int          RECIP100_SHIFT = 19;

    localparam logic [22:0] DAYS_PER_YEAR  = 23'd365;
    localparam logic [22:0] GREG_LEAPS_GAP = 23'd464;  // 1916/4 - 1916/100 + 1916/400

    localparam logic [2:0] WEEKDAY_SAT = 3'd6;
    localparam logic [2:0] WEEKDAY_SUN = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [13:0] load_year;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic        date_ok;
        logic [2:0]  weekday;
    } t_out_item;

    typedef struct packed {
        logic step;      // input transfer: apply the item to the date
        logic wk_mul;    // weekday recount: year / 100
        logic wk_sum;    // weekday recount: day number
        logic wk_fold;   // weekday recount: octal digit sum
        logic wk_done;   // weekday recount: write weekday
        logic out_load;  // capture the current date into the output register
    } t_cmd;

    typedef struct packed {
        logic start_calc;  // offered item is a good load that needs a weekday recount
    } t_stat;

    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        if (y <= GAP_YEAR) begin
            return div4;
        end
        return (div4 && !div25) || (div16 && div25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m
    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] cum;
        unique case (m)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

    function automatic logic date_good(input logic [4:0] d, input logic [3:0] m,
                                       input logic [13:0] y);
        logic ok;
        ok = 1'b1;
        if ((m == 4'd0) || (m > 4'd12)) begin
            ok = 1'b0;
        end
        if ((d == 5'd0) || (d > month_len(m, is_leap(y)))) begin
            ok = 1'b0;
        end
        if ((y == 14'd0) || ({18'd0, y} > 32'(YEAR_MAX))) begin
            ok = 1'b0;
        end
        if ((y == GAP_YEAR) && (m == 4'd4) && (d < GAP_END_DAY)) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // s is congruent to the day number mod 7; weekday is ((5 + n) mod 7) + 1
    function automatic logic [2:0] weekday_of_rem(input logic [5:0] s);
        logic [4:0] t;
        t = 5'({2'd0, s[5:3]} + {2'd0, s[2:0]}) + 5'd5;
        if (t >= 5'd14) begin
            t = t - 5'd14;
        end else if (t >= 5'd7) begin
            t = t - 5'd7;
        end
        return 3'(t + 5'd1);
    endfunction

endpackage

[rtl/calendar_date_counter_unit.sv]
`timescale 1ns / 1ps
// calendar_date_counter_unit: top level of the julian/gregorian date counter
// instantiates caldc_ctrl and caldc_dp; uses caldc_pkg
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one command per transfer:
// load a date, advance one day, or clear to 1.1.1. Every command gives exactly one
// result on the output channel (o_out_valid / i_out_ready / o_out_data): the date
// after the command, with zeros and date_ok low while the date is invalid.
// Advance, clear, a refused load and an unused code take effect at the transfer;
// their result then passes into the output register, and they sustain one per
// cycle while the receiver takes results. A good load recounts the weekday from
// 1.1.1 in four steps of the datapath (year/100, day number, octal digit sum,
// weekday); the input is held off until the weekday step has written the result.
// The date registers hold one finished result while the output register waits,
// so a stalled receiver costs at most one more accepted command before
// o_in_ready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) sets the date to 1.1.1, valid, Saturday, and
// empties the output register.
module calendar_date_counter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  caldc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output caldc_pkg::t_out_item o_out_data
);
    import caldc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    caldc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    caldc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

    // an invalid date reads back as all zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.date_ok) |->
            (o_out_data.cur_day == 5'd0 && o_out_data.cur_month == 4'd0
             && o_out_data.cur_year == 14'd0 && o_out_data.weekday == 3'd0))
        else $error("invalid date not zeroed");

    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.date_ok) |->
            (o_out_data.weekday != 3'd0 && o_out_data.cur_month != 4'd0
             && o_out_data.cur_day != 5'd0 && o_out_data.cur_year != 14'd0))
        else $error("valid date with zero field");

    // a good load holds off the input for the whole recount
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && stat.start_calc) |=> (!o_in_ready ##1 !o_in_ready
                                           ##1 !o_in_ready ##1 !o_in_ready))
        else $error("input accepted during weekday recount");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("output capture lost");

endmodule

[rtl/caldc_ctrl.sv]
`timescale 1ns / 1ps
// caldc_ctrl: handshake and sequencing of the date counter
// steps the weekday recount after a load and owns the output valid flag; uses caldc_pkg
module caldc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  caldc_pkg::t_stat i_stat,
    output caldc_pkg::t_cmd  o_cmd
);
    import caldc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_FOLD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   accept;
    logic   out_load;

    assign out_free = !r_out_valid || i_out_ready;
    // a finished result may sit in the date registers while the output is full
    assign in_ready = (r_state == S_IDLE) && (!r_pend || out_free);
    assign accept   = i_in_valid && in_ready;
    assign out_load = r_pend && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_stat.start_calc) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_FOLD;
            S_FOLD: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        priority if ((accept && !i_stat.start_calc) || (r_state == S_DONE)) begin
            n_pend = 1'b1;
        end else if (out_load) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end

        priority if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = accept;
        o_cmd.wk_mul   = (r_state == S_MUL);
        o_cmd.wk_sum   = (r_state == S_SUM);
        o_cmd.wk_fold  = (r_state == S_FOLD);
        o_cmd.wk_done  = (r_state == S_DONE);
        o_cmd.out_load = out_load;
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

[rtl/caldc_dp.sv]
`timescale 1ns / 1ps
// caldc_dp: date registers, day advance, load check, weekday recount and output register
// driven by caldc_ctrl commands; uses caldc_pkg
module caldc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  caldc_pkg::t_in_item  i_in_data,
    input  caldc_pkg::t_cmd      i_cmd,
    output caldc_pkg::t_stat     o_stat,
    output caldc_pkg::t_out_item o_out_data
);
    import caldc_pkg::*;

    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic        r_valid;
    logic [2:0]  r_weekday;

    // weekday recount
    logic [13:0] r_prev;
    logic [8:0]  r_cum;
    logic [7:0]  r_q100;
    logic [22:0] r_n;
    logic [5:0]  r_s;

    t_out_item   r_out;

    logic        in_ok;
    logic        in_leap;
    logic        cur_leap;
    logic [4:0]  cur_len;
    logic [14:0] year_inc;
    logic        year_over;
    logic [2:0]  weekday_inc;
    logic [8:0]  in_cum;
    logic [26:0] q_prod;
    logic [22:0] n_sum;
    logic [22:0] jul_part;
    logic [22:0] greg_part;
    logic [22:0] prev_w;
    logic [23:0] n_pad;
    logic [5:0]  s_sum;

    assign in_ok    = date_good(i_in_data.load_day, i_in_data.load_month, i_in_data.load_year);
    assign in_leap  = is_leap(i_in_data.load_year);
    assign cur_leap = is_leap(r_year);
    assign cur_len  = month_len(r_month, cur_leap);
    assign year_inc = {1'b0, r_year} + 15'd1;
    assign year_over = year_inc[14] || ({17'd0, year_inc} > 32'(YEAR_MAX));
    assign weekday_inc = (r_weekday == WEEKDAY_SUN) ? 3'd1 : r_weekday + 3'd1;

    assign o_stat.start_calc = (i_in_data.func == FUNC_LOAD) && r_valid && in_ok;

    // day offset inside the loaded year, with the april gap taken out
    always_comb begin
        in_cum = days_before(i_in_data.load_month, in_leap)
               + {4'd0, i_in_data.load_day} - 9'd1;
        if ((i_in_data.load_year == GAP_YEAR) && (i_in_data.load_month >= 4'd4)) begin
            in_cum = in_cum - {4'd0, GAP_DAYS};
        end
    end

    assign q_prod = {13'd0, r_prev} * RECIP100;

    always_comb begin
        prev_w   = {9'd0, r_prev};
        jul_part = (r_prev < GAP_YEAR) ? (prev_w >> 2) : ({9'd0, GAP_YEAR} >> 2);
        if (r_prev > GAP_YEAR) begin
            greg_part = (prev_w >> 2) - {15'd0, r_q100} + ({15'd0, r_q100} >> 2)
                      - GREG_LEAPS_GAP;
        end else begin
            greg_part = '0;
        end
        n_sum = prev_w * DAYS_PER_YEAR + jul_part + greg_part + {14'd0, r_cum};
        if (r_prev >= GAP_YEAR) begin
            n_sum = n_sum - {18'd0, GAP_DAYS};
        end
    end

    // 8 is 1 mod 7, so the octal digits sum to the same residue
    always_comb begin
        n_pad = {1'b0, r_n};
        s_sum = '0;
        for (int k = 0; k < 8; k++) begin
            s_sum = s_sum + {3'd0, n_pad[3*k +: 3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day     <= 5'd1;
            r_month   <= 4'd1;
            r_year    <= 14'd1;
            r_valid   <= 1'b1;
            r_weekday <= WEEKDAY_SAT;
        end else if (i_cmd.step) begin
            unique case (i_in_data.func)
                FUNC_LOAD: begin
                    if (r_valid) begin
                        r_day   <= i_in_data.load_day;
                        r_month <= i_in_data.load_month;
                        r_year  <= i_in_data.load_year;
                        r_valid <= in_ok;
                    end
                end
                FUNC_NEXT: begin
                    if (r_valid) begin
                        priority if ((r_year == GAP_YEAR) && (r_month == 4'd3)
                                     && (r_day == 5'd31)) begin
                            r_day     <= GAP_END_DAY;
                            r_month   <= 4'd4;
                            r_weekday <= weekday_inc;
                        end else if (({1'b0, r_day} + 6'd1) > {1'b0, cur_len}) begin
                            r_day <= 5'd1;
                            if (r_month == 4'd12) begin
                                r_month <= 4'd1;
                                r_year  <= year_inc[13:0];
                                if (year_over) begin
                                    r_valid <= 1'b0;
                                end else begin
                                    r_weekday <= weekday_inc;
                                end
                            end else begin
                                r_month   <= r_month + 4'd1;
                                r_weekday <= weekday_inc;
                            end
                        end else begin
                            r_day     <= r_day + 5'd1;
                            r_weekday <= weekday_inc;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    r_day     <= 5'd1;
                    r_month   <= 4'd1;
                    r_year    <= 14'd1;
                    r_valid   <= 1'b1;
                    r_weekday <= WEEKDAY_SAT;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.wk_done) begin
            r_weekday <= weekday_of_rem(r_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_prev <= i_in_data.load_year - 14'd1;
            r_cum  <= in_cum;
        end
        if (i_cmd.wk_mul) begin
            r_q100 <= q_prod[RECIP100_SHIFT +: 8];
        end
        if (i_cmd.wk_sum) begin
            r_n <= n_sum;
        end
        if (i_cmd.wk_fold) begin
            r_s <= s_sum;
        end
        if (i_cmd.out_load) begin
            r_out.cur_day   <= r_valid ? r_day : 5'd0;
            r_out.cur_month <= r_valid ? r_month : 4'd0;
            r_out.cur_year  <= r_valid ? r_year : 14'd0;
            r_out.date_ok   <= r_valid;
            r_out.weekday   <= r_valid ? r_weekday : 3'd0;
        end
    end

    assign o_out_data = r_out;

endmodule
